FILE: hw/rtl/rc_pkg.sv
// Shared types, constants and helper functions for the radix converter.
package rc_pkg;

    localparam int VALUE_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int DIV_STEPS       = 8;   // quotient bits resolved per divide cycle
    localparam int MAX_DIGITS      = 32;
    localparam int DIGIT_IDX_W     = $clog2(MAX_DIGITS);
    localparam int DIGIT_CNT_W     = DIGIT_IDX_W + 1;
    localparam int DIGIT_W         = 6;
    localparam int VALUE_OUT_W     = 32;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 6;

    localparam logic [CFG_IDX_W-1:0] REG_IN_BASE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_BASE = 2'd1;

    localparam logic [DIGIT_W-1:0] BASE_MIN       = 6'd2;
    localparam logic [DIGIT_W-1:0] BASE_MAX       = 6'd36;
    localparam logic [DIGIT_W-1:0] IN_BASE_RESET  = 6'd10;
    localparam logic [DIGIT_W-1:0] OUT_BASE_RESET = 6'd2;

    localparam logic [7:0] CHAR_ZERO    = 8'd48;  // '0'
    localparam logic [7:0] CHAR_NINE    = 8'd57;  // '9'
    localparam logic [7:0] CHAR_UP_A    = 8'd65;  // 'A'
    localparam logic [7:0] CHAR_UP_Z    = 8'd90;  // 'Z'
    localparam logic [7:0] CHAR_LO_A    = 8'd97;  // 'a'
    localparam logic [7:0] CHAR_LO_Z    = 8'd122; // 'z'
    localparam logic [7:0] LETTER_OFS   = 8'd55;  // 'A' - 10
    localparam logic [7:0] LOWER_OFS    = 8'd87;  // 'a' - 10
    localparam logic [7:0] CHAR_ERROR   = 8'd0;
    localparam logic [DIGIT_W-1:0] MAX_DEC_DIGIT = 6'd9;

    typedef struct packed {
        logic [7:0] char_code;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0]             digit_code;
        logic [VALUE_OUT_W-1:0] value;
        logic                   bad_char;
        logic                   last_digit;
    } t_out_item;

    // Classified character as it travels from front to back.
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               bad;
        logic               last;
    } t_cls;

    typedef struct packed {
        logic [DIGIT_W-1:0] in_base;
        logic [DIGIT_W-1:0] out_base;
    } t_bases;

    typedef enum logic [2:0] {
        BS_ACC,
        BS_DIV,
        BS_READ,
        BS_EMIT,
        BS_ERR
    } t_bstate;

    function automatic logic [DIGIT_W-1:0] clamp_base(input logic [DIGIT_W-1:0] b);
        logic [DIGIT_W-1:0] r;
        r = b;
        if (b < BASE_MIN) r = BASE_MIN;
        if (b > BASE_MAX) r = BASE_MAX;
        return r;
    endfunction

    function automatic t_cls char_to_digit(input logic [7:0] c);
        t_cls r;
        logic [7:0] d;
        d      = 8'd0;
        r.bad  = 1'b0;
        r.last = 1'b0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            d = c - CHAR_ZERO;
        end else if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            d = c - LETTER_OFS;
        end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
            d = c - LOWER_OFS;
        end else begin
            r.bad = 1'b1;
        end
        r.digit = d[DIGIT_W-1:0];
        return r;
    endfunction

    function automatic logic [7:0] digit_to_char(input logic [DIGIT_W-1:0] d);
        logic [7:0] r;
        if (d <= MAX_DEC_DIGIT) r = {2'b00, d} + CHAR_ZERO;
        else                    r = {2'b00, d} + LETTER_OFS;
        return r;
    endfunction

endpackage

FILE: hw/rtl/rc_front.sv
// Front end: accepts characters and classifies them into digit values.
module rc_front (
    input  rc_pkg::t_in_item i_item,
    input  logic             i_push,
    input  logic             i_q_full,
    output logic             o_q_wr,
    output rc_pkg::t_cls     o_q_data
);
    import rc_pkg::*;

    t_cls cls;

    always_comb begin
        cls      = char_to_digit(i_item.char_code);
        cls.last = i_item.is_last;
    end

    assign o_q_wr   = i_push && !i_q_full;
    assign o_q_data = cls;

endmodule

FILE: hw/rtl/rc_queue.sv
// Short queue of classified characters between front and back.
module rc_queue #(
    parameter int DEPTH = rc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_wr,
    input  rc_pkg::t_cls i_data,
    output logic         o_full,
    input  logic         i_rd,
    output logic         o_valid,
    output rc_pkg::t_cls o_data
);
    import rc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cls             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_wr;
    logic             do_rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_wr   = i_wr && !o_full;
    assign do_rd   = i_rd && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/rc_back.sv
// Back end: accumulates digits, splits the value into output digits, emits them.
module rc_back #(
    parameter int VALUE_WIDTH = rc_pkg::VALUE_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rc_pkg::t_bases    i_bases,
    input  logic              i_q_valid,
    input  rc_pkg::t_cls      i_q_data,
    output logic              o_q_rd,
    output logic              o_empty,
    input  logic              i_pop,
    output rc_pkg::t_out_item o_item
);
    import rc_pkg::*;

    localparam int NCHUNK  = (VALUE_WIDTH + DIV_STEPS - 1) / DIV_STEPS;
    localparam int QW      = NCHUNK * DIV_STEPS;
    localparam int CHUNK_W = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;

    t_bstate r_state;
    t_bstate n_state;

    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_err;
    logic [VALUE_WIDTH-1:0] r_val;
    logic [QW-1:0]          r_quo;
    logic [DIGIT_W-1:0]     r_rem;
    logic [CHUNK_W-1:0]     r_chunk;
    logic [DIGIT_CNT_W-1:0] r_cnt;
    logic [DIGIT_IDX_W-1:0] r_rd_idx;
    logic [DIGIT_W-1:0]     r_rd_data;
    logic [DIGIT_W-1:0]     r_mem [MAX_DIGITS];
    logic                   r_ov;
    t_out_item              r_out;

    logic [DIGIT_W-1:0]     in_b;
    logic [DIGIT_W-1:0]     out_b;
    logic [VALUE_WIDTH-1:0] acc_mul;
    logic [VALUE_WIDTH-1:0] acc_new;
    logic                   err_total;
    logic [QW-1:0]          q_nx;
    logic [DIGIT_W-1:0]     rem_nx;
    logic                   chunk_last;
    logic                   div_done;
    logic                   out_ready;
    logic                   out_push;
    t_out_item              out_nx;
    logic [63:0]            val_wide;

    assign in_b      = clamp_base(i_bases.in_base);
    assign out_b     = clamp_base(i_bases.out_base);
    assign acc_mul   = r_acc * VALUE_WIDTH'(in_b);
    assign acc_new   = i_q_data.bad ? r_acc : acc_mul + VALUE_WIDTH'(i_q_data.digit);
    assign err_total = r_err || i_q_data.bad;
    assign out_ready = !r_ov || i_pop;
    assign val_wide  = 64'(r_val);

    // Restoring division, DIV_STEPS quotient bits per cycle; the remainder stays narrow.
    always_comb begin
        logic [QW-1:0]      q;
        logic [DIGIT_W-1:0] rem;
        logic [DIGIT_W:0]   t;
        q   = r_quo;
        rem = r_rem;
        for (int k = 0; k < DIV_STEPS; k++) begin
            t = {rem, q[QW-1]};
            q = {q[QW-2:0], 1'b0};
            if (t >= {1'b0, out_b}) begin
                t    = t - {1'b0, out_b};
                q[0] = 1'b1;
            end
            rem = t[DIGIT_W-1:0];
        end
        q_nx   = q;
        rem_nx = rem;
    end

    assign chunk_last = (r_chunk == CHUNK_W'(NCHUNK - 1));
    assign div_done   = chunk_last &&
                        ((q_nx == '0) || (r_cnt == DIGIT_CNT_W'(MAX_DIGITS - 1)));

    always_comb begin
        n_state = r_state;
        case (r_state)
            BS_ACC: begin
                if (i_q_valid && i_q_data.last) begin
                    n_state = err_total ? BS_ERR : BS_DIV;
                end
            end
            BS_DIV: begin
                if (div_done) n_state = BS_READ;
            end
            BS_READ: n_state = BS_EMIT;
            BS_EMIT: begin
                if (out_ready) n_state = (r_rd_idx == '0) ? BS_ACC : BS_READ;
            end
            BS_ERR: begin
                if (out_ready) n_state = BS_ACC;
            end
            default: n_state = BS_ACC;
        endcase
    end

    always_comb begin
        o_q_rd            = 1'b0;
        out_push          = 1'b0;
        out_nx.digit_code = digit_to_char(r_rd_data);
        out_nx.value      = val_wide[VALUE_OUT_W-1:0];
        out_nx.bad_char   = 1'b0;
        out_nx.last_digit = (r_rd_idx == '0);
        case (r_state)
            BS_ACC:  o_q_rd = i_q_valid;
            BS_EMIT: out_push = out_ready;
            BS_ERR: begin
                out_push          = out_ready;
                out_nx.digit_code = CHAR_ERROR;
                out_nx.bad_char   = 1'b1;
                out_nx.last_digit = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BS_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_err <= 1'b0;
            r_cnt <= '0;
        end else if (o_q_rd) begin
            if (i_q_data.last) begin
                // Start over for the next number.
                r_acc <= '0;
                r_err <= 1'b0;
                r_cnt <= '0;
            end else begin
                r_acc <= acc_new;
                r_err <= err_total;
            end
        end else if (r_state == BS_DIV && chunk_last) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd && i_q_data.last) begin
            r_val   <= acc_new;
            r_quo   <= QW'(acc_new);
            r_rem   <= '0;
            r_chunk <= '0;
        end else if (r_state == BS_DIV) begin
            r_quo <= q_nx;
            if (chunk_last) begin
                r_rem    <= '0;
                r_chunk  <= '0;
                r_rd_idx <= r_cnt[DIGIT_IDX_W-1:0];
            end else begin
                r_rem   <= rem_nx;
                r_chunk <= r_chunk + 1'b1;
            end
        end else if (r_state == BS_EMIT && out_ready) begin
            r_rd_idx <= r_rd_idx - 1'b1;
        end
    end

    // Digit store: written least significant first, read back in reverse.
    always_ff @(posedge i_clk) begin
        if (r_state == BS_DIV && chunk_last) begin
            r_mem[r_cnt[DIGIT_IDX_W-1:0]] <= rem_nx;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_push) begin
            r_ov <= 1'b1;
        end else if (i_pop) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_push) begin
            r_out <= out_nx;
        end
    end

    assign o_empty = !r_ov;
    assign o_item  = r_out;

endmodule

FILE: hw/rtl/radix_converter.sv
// Top level of the radix converter: configuration registers, front, queue and back.
//
//   channel   | handshake         | payload
//   ----------+-------------------+-----------------------------------------
//   input     | push / full       | i_in  (char_code, is_last)
//   result    | pop / empty       | o_out (digit_code, value, bad_char, last_digit)
//   config    | i_cfg_we          | i_cfg_idx, i_cfg_data
//
// A character that is not last is folded into the accumulator as it leaves the queue.
// Unless a bad character was seen, a last character starts the divide unit, which
// splits the value into output digits and writes them to the digit store; each digit
// is then read back and loaded into the output register. The front keeps filling the
// queue meanwhile. Reset is synchronous and active low and empties the character queue
// and the result register. The result register holds until pop; while it is full the
// back end holds its next output item, and the character queue fills behind it.
module radix_converter #(
    parameter int VALUE_WIDTH = rc_pkg::VALUE_WIDTH_DEF,
    parameter int QUEUE_DEPTH = rc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  rc_pkg::t_in_item              i_in,
    output logic                          empty,
    input  logic                          pop,
    output rc_pkg::t_out_item             o_out,
    input  logic                          i_cfg_we,
    input  logic [rc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rc_pkg::*;

    t_bases r_bases;
    logic   q_wr;
    t_cls   q_wdata;
    logic   q_full;
    logic   q_rd;
    logic   q_valid;
    t_cls   q_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bases.in_base  <= IN_BASE_RESET;
            r_bases.out_base <= OUT_BASE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IN_BASE:  r_bases.in_base  <= i_cfg_data;
                REG_OUT_BASE: r_bases.out_base <= i_cfg_data;
                default: ;
            endcase
        end
    end

    rc_front u_front (
        .i_item   (i_in),
        .i_push   (push),
        .i_q_full (q_full),
        .o_q_wr   (q_wr),
        .o_q_data (q_wdata)
    );

    rc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (q_wdata),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_valid (q_valid),
        .o_data  (q_rdata)
    );

    rc_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_bases   (r_bases),
        .i_q_valid (q_valid),
        .i_q_data  (q_rdata),
        .o_q_rd    (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_item    (o_out)
    );

    assign full = q_full;

endmodule

FILE: hw/rtl/rc_checker.sv
// Port-level checks on the radix converter, bound to the top level.
module rc_sva (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              empty,
    input logic              pop,
    input rc_pkg::t_out_item o_out
);
    import rc_pkg::*;

    // Nothing is shown right after reset.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // A waiting result holds until taken.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("waiting result changed");

    // An error transaction is a single flagged item with a null code.
    a_error_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.bad_char) |-> (o_out.last_digit && o_out.digit_code == CHAR_ERROR))
        else $error("malformed error transaction");

    // Digit codes are always printable digits or capitals.
    a_digit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_out.bad_char) |->
        ((o_out.digit_code >= CHAR_ZERO && o_out.digit_code <= CHAR_NINE) ||
         (o_out.digit_code >= CHAR_UP_A && o_out.digit_code <= CHAR_UP_Z)))
        else $error("digit code out of range");

endmodule

bind radix_converter rc_sva u_rc_sva (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out)
);

FILE: verif/rc_checker.sv
// Scoreboard for the radix converter: predicts result transactions and compares them.
module rc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic                          i_full,
    input  rc_pkg::t_in_item              i_in,
    input  logic                          i_empty,
    input  logic                          i_pop,
    input  rc_pkg::t_out_item             i_out,
    input  logic                          i_cfg_we,
    input  logic [rc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [rc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rc_pkg::*;

    logic [VALUE_OUT_W-1:0] number_acc;
    logic                   bad_seen;
    logic [DIGIT_W-1:0]     in_radix;
    logic [DIGIT_W-1:0]     out_radix;
    t_out_item              expected_digits[$];

    // -1 marks a character that is neither a digit nor a letter
    function automatic int char_weight(input logic [7:0] c);
        if (c >= CHAR_ZERO && c <= CHAR_NINE) return int'(c) - int'(CHAR_ZERO);
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) return int'(c) - int'(CHAR_UP_A) + 10;
        if (c >= CHAR_LO_A && c <= CHAR_LO_Z) return int'(c) - int'(CHAR_LO_A) + 10;
        return -1;
    endfunction

    function automatic int unsigned usable_radix(input logic [DIGIT_W-1:0] b);
        if (b < 2) return 2;
        if (b > 36) return 36;
        return 32'(b);
    endfunction

    function automatic logic [7:0] weight_ascii(input logic [DIGIT_W-1:0] d);
        if (d < 10) return 8'(CHAR_ZERO + d);
        return 8'(CHAR_UP_A + d - 10);
    endfunction

    // Fold one character in; on the last one, queue the converted digits or an error item.
    function automatic void fold_char(input t_in_item it);
        int                     w;
        int unsigned            ob;
        logic [63:0]            wide;
        logic [VALUE_OUT_W-1:0] rest;
        logic [DIGIT_W-1:0]     msd_first[$];
        t_out_item              r;
        w = char_weight(it.char_code);
        if (w < 0) begin
            bad_seen = 1'b1;
        end else begin
            wide = {32'd0, number_acc} * 64'(usable_radix(in_radix)) + 64'(w);
            number_acc = wide[VALUE_OUT_W-1:0];
        end
        if (!it.is_last) return;
        if (bad_seen) begin
            r.digit_code = CHAR_ERROR;
            r.value      = number_acc;
            r.bad_char   = 1'b1;
            r.last_digit = 1'b1;
            expected_digits.push_back(r);
        end else begin
            ob   = usable_radix(out_radix);
            rest = number_acc;
            if (rest == 0) msd_first.push_front('0);
            while (rest != 0) begin
                msd_first.push_front(DIGIT_W'(rest % ob));
                rest = rest / ob;
            end
            foreach (msd_first[k]) begin
                r.digit_code = weight_ascii(msd_first[k]);
                r.value      = number_acc;
                r.bad_char   = 1'b0;
                r.last_digit = (k == msd_first.size() - 1);
                expected_digits.push_back(r);
            end
        end
        number_acc = '0;
        bad_seen   = 1'b0;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            number_acc = '0;
            bad_seen   = 1'b0;
            in_radix   = IN_BASE_RESET;
            out_radix  = OUT_BASE_RESET;
            expected_digits.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_IN_BASE)  in_radix  = i_cfg_data;
                if (i_cfg_idx == REG_OUT_BASE) out_radix = i_cfg_data;
            end
            // compare before predicting so a result cannot match its own transaction
            if (i_pop && !i_empty) begin
                if (expected_digits.size() == 0) begin
                    $error("unexpected result: digit_code %0d value %0d bad_char %0d",
                           i_out.digit_code, i_out.value, i_out.bad_char);
                    o_fail_count++;
                end else begin
                    want = expected_digits.pop_front();
                    if (i_out.digit_code !== want.digit_code) begin
                        $error("digit_code: expected %0d, actual %0d",
                               want.digit_code, i_out.digit_code);
                        o_fail_count++;
                    end
                    if (i_out.value !== want.value) begin
                        $error("value: expected %0d, actual %0d", want.value, i_out.value);
                        o_fail_count++;
                    end
                    if (i_out.bad_char !== want.bad_char) begin
                        $error("bad_char: expected %0d, actual %0d",
                               want.bad_char, i_out.bad_char);
                        o_fail_count++;
                    end
                    if (i_out.last_digit !== want.last_digit) begin
                        $error("last_digit: expected %0d, actual %0d",
                               want.last_digit, i_out.last_digit);
                        o_fail_count++;
                    end
                end
            end
            if (i_push && !i_full) fold_char(i_in);
        end
        o_pending = expected_digits.size();
    end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the radix converter: clock, reset, stimulus and verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import rc_pkg::*;

    typedef enum int {NUM_CLEAN, NUM_NOISY, NUM_WIDE_DIGITS} t_num_flavor;

    logic                  i_clk   = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  push    = 1'b0;
    logic                  full;
    t_in_item              in_item = '0;
    logic                  empty;
    logic                  pop     = 1'b0;
    t_out_item             out_item;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    int                    fail_count;
    int                    pending;
    logic                  hold_req = 1'b0;
    int                    burst_left = 0;

    radix_converter DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .push      (push),
        .full      (full),
        .i_in      (in_item),
        .empty     (empty),
        .pop       (pop),
        .o_out     (out_item),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data)
    );

    rc_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_full      (full),
        .i_in        (in_item),
        .i_empty     (empty),
        .i_pop       (pop),
        .i_out       (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Offer one character; return at the edge that takes the transaction.
    task automatic send_char(input logic [7:0] code, input logic last);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                @(negedge i_clk);
                push    = 1'b0;
                in_item = t_in_item'($bits(t_in_item)'($urandom));
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        push              = 1'b1;
        in_item.char_code = code;
        in_item.is_last   = last;
        do @(posedge i_clk); while (full);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    task automatic send_number(input int len, input int radix, input t_num_flavor flavor);
        int         d;
        logic [7:0] code;
        for (int i = 0; i < len; i++) begin
            if (flavor == NUM_NOISY && $urandom_range(2) == 0) begin
                code = 8'($urandom_range(255));
            end else begin
                d = (flavor == NUM_WIDE_DIGITS) ? $urandom_range(35) : $urandom_range(radix - 1);
                if (d < 10) code = 8'(CHAR_ZERO + d);
                else        code = 8'(($urandom_range(1) ? CHAR_UP_A : CHAR_LO_A) + d - 10);
            end
            send_char(code, i == len - 1);
        end
    endtask

    // Stop offering, let every expected result out, then let the back end settle.
    task automatic drain();
        @(negedge i_clk);
        push = 1'b0;
        for (int n = 0; n < 50000 && pending != 0; n++) @(negedge i_clk);
        repeat (250) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = CFG_DATA_W'(data);
        @(negedge i_clk);
        cfg_we   = 1'b0;
    endtask

    // Result side: stall on a changing pattern; hold off for a long stretch on request.
    initial begin : result_side
        int   stall_pct;
        int   left;
        logic held;
        stall_pct = 0;
        left      = 0;
        held      = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                pop  = 1'b0;
                repeat (400) @(negedge i_clk);
            end
            if (left == 0) begin
                left = $urandom_range(16, 96);
                case ($urandom_range(3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 60;
                    default: stall_pct = 85;
                endcase
            end
            left--;
            pop = ($urandom_range(99) >= stall_pct);
        end
    end

    initial begin : stimulus
        int          in_tab[6];
        int          out_tab[6];
        int          in_b;
        int          out_b;
        int          radix;
        int          phase_items;
        int          numbers;
        int          len;
        int          pick;
        t_num_flavor flavor;
        in_tab  = '{2, 36, 0, 63, 8, 10};
        out_tab = '{36, 10, 1, 37, 16, 2};
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        write_reg(REG_IN_BASE, 10);
        write_reg(REG_OUT_BASE, 2);
        send_text("0");
        // letters of both cases, digits above the input radix
        send_text("zZaA9");
        send_char(8'd0, 1'b0);
        send_char(8'd255, 1'b0);
        // invalid characters on both sides of each range, the last one invalid too
        send_text("/:@[`{");
        send_text("7");
        drain();
        write_reg(REG_IN_BASE, 16);
        send_text("FFFFFFFF");

        for (int p = 0; p < 8; p++) begin
            drain();
            in_b  = (p < 6) ? in_tab[p] : $urandom_range(0, 63);
            out_b = (p < 6) ? out_tab[p] : $urandom_range(0, 63);
            write_reg(REG_IN_BASE, in_b);
            write_reg(REG_OUT_BASE, out_b);
            radix       = (in_b < 2) ? 2 : (in_b > 36) ? 36 : in_b;
            phase_items = 0;
            numbers     = 0;
            while (phase_items < 50) begin
                len  = ($urandom_range(7) == 0) ? $urandom_range(11, 40) : $urandom_range(1, 8);
                pick = $urandom_range(7);
                flavor = (pick < 6) ? NUM_CLEAN : (pick == 6) ? NUM_NOISY : NUM_WIDE_DIGITS;
                send_number(len, radix, flavor);
                phase_items += len;
                numbers++;
                // starve the result side while characters keep coming
                if (p == 1 && numbers == 1) hold_req = 1'b1;
            end
        end
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
